@@ design/prc_pkg.sv @@
// ----------------------------------------------------------------------------
// Probe reply classifier package
// Shared codes, header offsets and capture slot map.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;

  // Minimum packet lengths
  localparam logic [CNT_W-1:0] LEN_IP       = 6'd20;
  localparam logic [CNT_W-1:0] LEN_ICMP_MIN = 6'd28;
  localparam logic [CNT_W-1:0] LEN_UDP_MIN  = 6'd28;
  localparam logic [CNT_W-1:0] LEN_TCP_MIN  = 6'd40;
  localparam logic [CNT_W-1:0] LEN_ERR_MIN  = 6'd56;

  // IP protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // ICMP types
  localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
  localparam logic [7:0] ICMP_UNREACH    = 8'd3;
  localparam logic [7:0] ICMP_ECHO_REQ   = 8'd8;
  localparam logic [7:0] ICMP_TIME_EXC   = 8'd11;

  // TCP flag bit positions
  localparam int FLAG_FIN = 0;
  localparam int FLAG_SYN = 1;
  localparam int FLAG_RST = 2;
  localparam int FLAG_PSH = 3;
  localparam int FLAG_ACK = 4;
  localparam int FLAG_URG = 5;

  // Reply kinds
  localparam logic [3:0] KIND_NONE       = 4'd0;
  localparam logic [3:0] KIND_ECHO       = 4'd1;
  localparam logic [3:0] KIND_ACK        = 4'd2;
  localparam logic [3:0] KIND_SYN        = 4'd3;
  localparam logic [3:0] KIND_FIN        = 4'd4;
  localparam logic [3:0] KIND_UDP        = 4'd5;
  localparam logic [3:0] KIND_ECHO_REPLY = 4'd6;
  localparam logic [3:0] KIND_RST        = 4'd7;
  localparam logic [3:0] KIND_RST_ACK    = 4'd8;
  localparam logic [3:0] KIND_SYN_ACK    = 4'd9;
  localparam logic [3:0] KIND_TIME_EXC   = 4'd10;
  localparam logic [3:0] KIND_UNREACH    = 4'd11;

  // Inner probe kinds
  localparam logic [1:0] INNER_NONE = 2'd0;
  localparam logic [1:0] INNER_ECHO = 2'd1;
  localparam logic [1:0] INNER_TCP  = 2'd2;
  localparam logic [1:0] INNER_UDP  = 2'd3;

  // Only the header bytes that classification looks at are kept
  localparam int NUM_SLOTS = 20;
  localparam int S_B0   = 0;
  localparam int S_B1   = 1;
  localparam int S_PROT = 2;
  localparam int S_B20  = 3;
  localparam int S_B21  = 4;
  localparam int S_B24  = 5;
  localparam int S_B25  = 6;
  localparam int S_B26  = 7;
  localparam int S_B27  = 8;
  localparam int S_B28  = 9;
  localparam int S_B29  = 10;
  localparam int S_B30  = 11;
  localparam int S_B31  = 12;
  localparam int S_B32  = 13;
  localparam int S_B33  = 14;
  localparam int S_B37  = 15;
  localparam int S_B48  = 16;
  localparam int S_B49  = 17;
  localparam int S_B54  = 18;
  localparam int S_B55  = 19;

  localparam logic [CNT_W-1:0] CAP_POS [NUM_SLOTS] = '{
    6'd0, 6'd1, 6'd9, 6'd20, 6'd21, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28,
    6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd37, 6'd48, 6'd49, 6'd54, 6'd55
  };

  typedef logic [NUM_SLOTS-1:0][7:0] slots_t;

  typedef struct packed {
    logic [3:0]  reply_kind;
    logic [7:0]  unreach_code;
    logic [1:0]  inner_kind;
    logic [15:0] seq_value;
    logic        accepted;
  } result_t;

endpackage

@@ design/prc_capture.sv @@
// ----------------------------------------------------------------------------
// Probe reply classifier header capture
// Counts packet bytes and keeps the header bytes used for classification.
// ----------------------------------------------------------------------------
module prc_capture (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [7:0]                 wr_byte,
  input  logic                       wr_last,
  output prc_pkg::slots_t            slots,
  output logic [prc_pkg::CNT_W-1:0]  pkt_len
);
  import prc_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] len_now;
  logic [CNT_W-1:0] len_r;
  slots_t           slots_r;

  // length including the byte being written, saturated
  assign len_now = (count_r == COUNT_MAX) ? COUNT_MAX : count_r + 6'd1;

  always_comb begin
    count_nxt = count_r;
    if (wr_en) begin
      count_nxt = wr_last ? '0 : len_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
    always_ff @(posedge clk) begin
      if (wr_en && count_r == CAP_POS[s]) begin
        slots_r[s] <= wr_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_last) begin
      len_r <= len_now;
    end
  end

  assign slots   = slots_r;
  assign pkt_len = len_r;

endmodule

@@ design/prc_classify.sv @@
// ----------------------------------------------------------------------------
// Probe reply classifier decision logic
// Fixed-offset compares on the captured header give one result.
// ----------------------------------------------------------------------------
module prc_classify (
  input  prc_pkg::slots_t            slots,
  input  logic [prc_pkg::CNT_W-1:0]  pkt_len,
  input  logic [15:0]                probe_id,
  output prc_pkg::result_t           result
);
  import prc_pkg::*;

  logic [3:0]  kind;
  logic [7:0]  flags;
  logic [7:0]  icmp_type;
  logic        is_err;
  logic        is_dec;
  logic [1:0]  inner;
  logic [15:0] id_sel;
  logic [15:0] seq_sel;
  logic        ok;

  assign flags     = slots[S_B33];
  assign icmp_type = slots[S_B20];

  always_comb begin
    kind = KIND_NONE;
    if (pkt_len >= LEN_IP) begin
      case (slots[S_PROT])
        PROTO_TCP: begin
          if (pkt_len >= LEN_TCP_MIN && !flags[FLAG_PSH] && !flags[FLAG_URG]) begin
            if (flags[FLAG_FIN]) begin
              kind = KIND_FIN;
            end else if (flags[FLAG_RST]) begin
              kind = flags[FLAG_ACK] ? KIND_RST_ACK : KIND_RST;
            end else if (flags[FLAG_SYN]) begin
              kind = flags[FLAG_ACK] ? KIND_SYN_ACK : KIND_SYN;
            end else if (flags[FLAG_ACK]) begin
              kind = KIND_ACK;
            end
          end
        end
        PROTO_ICMP: begin
          if (pkt_len >= LEN_ICMP_MIN) begin
            if (icmp_type == ICMP_ECHO_REQ) begin
              kind = KIND_ECHO;
            end else if (icmp_type == ICMP_ECHO_REPLY) begin
              kind = KIND_ECHO_REPLY;
            end else if (pkt_len >= LEN_ERR_MIN) begin
              if (icmp_type == ICMP_UNREACH) begin
                kind = KIND_UNREACH;
              end else if (icmp_type == ICMP_TIME_EXC) begin
                kind = KIND_TIME_EXC;
              end
            end
          end
        end
        PROTO_UDP: begin
          if (pkt_len >= LEN_UDP_MIN) begin
            kind = KIND_UDP;
          end
        end
        default: kind = KIND_NONE;
      endcase
    end
  end

  assign is_err = (kind == KIND_TIME_EXC) || (kind == KIND_UNREACH);
  assign is_dec = (kind == KIND_RST_ACK) || (kind == KIND_SYN_ACK);

  always_comb begin
    case (kind) inside
      KIND_ECHO_REPLY, KIND_RST:   id_sel = {slots[S_B24], slots[S_B25]};
      KIND_RST_ACK, KIND_SYN_ACK:  id_sel = {slots[S_B28], slots[S_B29]};
      KIND_TIME_EXC, KIND_UNREACH: id_sel = {slots[S_B32], slots[S_B33]};
      default:                     id_sel = {slots[S_B0], slots[S_B1]};
    endcase
  end

  // the reply kind, and for a quoted packet its inner probe, picks the sequence offset
  always_comb begin
    inner   = INNER_NONE;
    seq_sel = {slots[S_B26], slots[S_B27]};
    if (is_err) begin
      if (slots[S_B37] == PROTO_TCP) begin
        inner   = INNER_TCP;
        seq_sel = {slots[S_B54], slots[S_B55]};
      end else if (slots[S_B37] == PROTO_UDP) begin
        inner   = INNER_UDP;
        seq_sel = {slots[S_B48], slots[S_B49]};
      end else if (slots[S_B37] == PROTO_ICMP && slots[S_B48] == ICMP_ECHO_REQ) begin
        inner   = INNER_ECHO;
        seq_sel = {slots[S_B54], slots[S_B55]};
      end
    end else if (kind == KIND_UDP) begin
      seq_sel = {slots[S_B20], slots[S_B21]};
    end else if (is_dec) begin
      seq_sel = {slots[S_B30], slots[S_B31]};
    end
  end

  assign ok = (kind != KIND_NONE) && (id_sel == probe_id) && (!is_err || inner != INNER_NONE);

  always_comb begin
    result.reply_kind   = kind;
    result.unreach_code = (kind == KIND_UNREACH) ? slots[S_B21] : 8'd0;
    result.inner_kind   = inner;
    result.accepted     = ok;
    if (!ok) begin
      result.seq_value = 16'd0;
    end else if (is_dec) begin
      result.seq_value = seq_sel - 16'd1;
    end else begin
      result.seq_value = seq_sel;
    end
  end

endmodule

@@ design/probe_reply_classifier_top.sv @@
// The accepted last byte sets the pending flag, then the result is registered with out_valid.
// Throughput: one byte per cycle; the capture stage and the output register
// each hold one transaction, so only a stalled output holds off input.
// Reset clears the byte count, the pending flag, out_valid and probe_id (to 0);
// captured header bytes are not reset.
// ----------------------------------------------------------------------------
// Probe reply classifier top level
// Captures a received packet byte stream and classifies it on its last byte.
// ----------------------------------------------------------------------------
module probe_reply_classifier_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pkt_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_reply_kind,
  output logic [7:0]  out_unreach_code,
  output logic [1:0]  out_inner_kind,
  output logic [15:0] out_seq_value,
  output logic        out_accepted,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_probe_id
);
  import prc_pkg::*;

  logic [15:0]      probe_id_r;
  logic             cls_valid_r, cls_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          res_r;
  result_t          res;
  slots_t           slots;
  logic [CNT_W-1:0] pkt_len;
  logic             in_acc;
  logic             cls_go;

  // classification moves on whenever the output register is free or draining
  assign cls_go   = cls_valid_r && (!out_valid_r || out_ready);
  // hold input while a finished packet waits, or its bytes would be overwritten
  assign in_ready = !cls_valid_r || cls_go;
  assign in_acc   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  prc_capture u_capture (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc),
    .wr_byte (in_pkt_byte),
    .wr_last (in_last_byte),
    .slots   (slots),
    .pkt_len (pkt_len)
  );

  prc_classify u_classify (
    .slots    (slots),
    .pkt_len  (pkt_len),
    .probe_id (probe_id_r),
    .result   (res)
  );

  always_comb begin
    cls_valid_nxt = cls_valid_r;
    if (in_acc && in_last_byte) begin
      cls_valid_nxt = 1'b1;
    end else if (cls_go) begin
      cls_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cls_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_id_r  <= '0;
      cls_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        probe_id_r <= cfg_probe_id;
      end
      cls_valid_r <= cls_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cls_go) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_reply_kind   = res_r.reply_kind;
  assign out_unreach_code = res_r.unreach_code;
  assign out_inner_kind   = res_r.inner_kind;
  assign out_seq_value    = res_r.seq_value;
  assign out_accepted     = res_r.accepted;

endmodule

@@ bench/probe_reply_classifier_top_tb.sv @@
// ----------------------------------------------------------------------------
// Probe reply classifier testbench
// Sends IPv4 packets one byte per transaction and predicts each classification.
// A checker compares every result field with the oldest predicted one. Directed
// tests cover each reply kind but bare SYN and RST, and the length, flag and
// identifier corner cases. Random traffic then runs under the remaining idling
// mixes and new probe_id settings.
// ----------------------------------------------------------------------------
module probe_reply_classifier_top_tb;
  import prc_pkg::*;

  localparam int CAPTURE_BYTES  = 56;
  localparam int DRAIN_CYCLES   = 8;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int MAX_PRINTED    = 50;

  // Header offsets used for classification
  localparam int OFF_PROTO       = 9;
  localparam int OFF_ICMP_TYPE   = 20;
  localparam int OFF_ICMP_CODE   = 21;
  localparam int OFF_UDP_SEQ     = 20;
  localparam int OFF_ID_REPLY    = 24;
  localparam int OFF_SEQ         = 26;
  localparam int OFF_ID_TCP_ACK  = 28;
  localparam int OFF_ACK_LOW     = 30;
  localparam int OFF_ID_INNER    = 32;
  localparam int OFF_TCP_FLAGS   = 33;
  localparam int OFF_INNER_PROTO = 37;
  localparam int OFF_INNER_SEQ_U = 48;
  localparam int OFF_INNER_TYPE  = 48;
  localparam int OFF_INNER_SEQ   = 54;

  localparam logic [7:0] F_FIN = 8'h01 << FLAG_FIN;
  localparam logic [7:0] F_SYN = 8'h01 << FLAG_SYN;
  localparam logic [7:0] F_RST = 8'h01 << FLAG_RST;
  localparam logic [7:0] F_PSH = 8'h01 << FLAG_PSH;
  localparam logic [7:0] F_ACK = 8'h01 << FLAG_ACK;
  localparam logic [7:0] F_URG = 8'h01 << FLAG_URG;

  localparam logic [7:0] PROTO_OTHER     = 8'd47;
  localparam logic [7:0] ICMP_OTHER_TYPE = 8'd5;

  typedef logic [7:0] pkt_q_t [$];
  typedef enum {ID_MATCH, ID_WRONG, ID_RANDOM} id_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_pkt_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_reply_kind;
  logic [7:0]  out_unreach_code;
  logic [1:0]  out_inner_kind;
  logic [15:0] out_seq_value;
  logic        out_accepted;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_probe_id = 16'h0000;

  // Predictor state
  logic [7:0]  cap_mem [CAPTURE_BYTES];
  logic [5:0]  cap_count = '0;
  logic [15:0] cfg_id_model = 16'h0000;
  result_t     exp_q [$];
  result_t     exp_head;

  int unsigned snd_idle = 26;
  int unsigned rcv_idle = 86;
  int          hold_len = 0;
  int          hold_cnt = 0;
  int          bytes_sent = 0;
  int          mismatch_count = 0;
  int          cycle_cnt = 0;

  probe_reply_classifier_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pkt_byte      (in_pkt_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_reply_kind   (out_reply_kind),
    .out_unreach_code (out_unreach_code),
    .out_inner_kind   (out_inner_kind),
    .out_seq_value    (out_seq_value),
    .out_accepted     (out_accepted),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_probe_id     (cfg_probe_id)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL probe_reply_classifier_top");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] cap_rd(input int off);
    return (off < CAPTURE_BYTES) ? cap_mem[off] : 8'h00;
  endfunction

  function automatic logic [15:0] cap_rd16(input int off);
    return {cap_rd(off), cap_rd(off + 1)};
  endfunction

  function automatic logic [3:0] tcp_kind(input logic [7:0] fl);
    if (fl[FLAG_PSH] || fl[FLAG_URG]) return KIND_NONE;
    if (fl[FLAG_FIN]) return KIND_FIN;
    if (fl[FLAG_RST]) return fl[FLAG_ACK] ? KIND_RST_ACK : KIND_RST;
    if (fl[FLAG_SYN]) return fl[FLAG_ACK] ? KIND_SYN_ACK : KIND_SYN;
    if (fl[FLAG_ACK]) return KIND_ACK;
    return KIND_NONE;
  endfunction

  function automatic logic [3:0] packet_kind(input int size);
    logic [7:0] proto;
    logic [7:0] icmp_type;
    if (size < LEN_IP) return KIND_NONE;
    proto = cap_rd(OFF_PROTO);
    if (proto == PROTO_TCP) begin
      if (size < LEN_TCP_MIN) return KIND_NONE;
      return tcp_kind(cap_rd(OFF_TCP_FLAGS));
    end
    if (proto == PROTO_ICMP) begin
      if (size < LEN_ICMP_MIN) return KIND_NONE;
      icmp_type = cap_rd(OFF_ICMP_TYPE);
      if (icmp_type == ICMP_ECHO_REQ) return KIND_ECHO;
      if (icmp_type == ICMP_ECHO_REPLY) return KIND_ECHO_REPLY;
      if (size < LEN_ERR_MIN) return KIND_NONE;
      if (icmp_type == ICMP_UNREACH) return KIND_UNREACH;
      if (icmp_type == ICMP_TIME_EXC) return KIND_TIME_EXC;
      return KIND_NONE;
    end
    if (proto == PROTO_UDP) begin
      if (size < LEN_UDP_MIN) return KIND_NONE;
      return KIND_UDP;
    end
    return KIND_NONE;
  endfunction

  function automatic result_t classify_capture(input int size);
    result_t     r;
    logic [3:0]  kind;
    logic [7:0]  inner_proto;
    logic [15:0] id;
    logic        is_err;
    logic        ok;
    int          id_off;
    int          seq_off;
    r = '0;
    kind = packet_kind(size);
    is_err = (kind == KIND_TIME_EXC) || (kind == KIND_UNREACH);
    r.reply_kind = kind;
    if (kind == KIND_UNREACH) r.unreach_code = cap_rd(OFF_ICMP_CODE);
    case (kind) inside
      KIND_ECHO_REPLY, KIND_RST: id_off = OFF_ID_REPLY;
      KIND_RST_ACK, KIND_SYN_ACK: id_off = OFF_ID_TCP_ACK;
      KIND_TIME_EXC, KIND_UNREACH: id_off = OFF_ID_INNER;
      default: id_off = 0;
    endcase
    id = cap_rd16(id_off);
    seq_off = OFF_SEQ;
    r.inner_kind = INNER_NONE;
    if (is_err) begin
      inner_proto = cap_rd(OFF_INNER_PROTO);
      if (inner_proto == PROTO_TCP) begin
        r.inner_kind = INNER_TCP;
        seq_off = OFF_INNER_SEQ;
      end else if (inner_proto == PROTO_UDP) begin
        r.inner_kind = INNER_UDP;
        seq_off = OFF_INNER_SEQ_U;
      end else if (inner_proto == PROTO_ICMP && cap_rd(OFF_INNER_TYPE) == ICMP_ECHO_REQ) begin
        r.inner_kind = INNER_ECHO;
        seq_off = OFF_INNER_SEQ;
      end
    end else if (kind == KIND_UDP) begin
      seq_off = OFF_UDP_SEQ;
    end else if (kind == KIND_RST_ACK || kind == KIND_SYN_ACK) begin
      seq_off = OFF_ACK_LOW;
    end
    ok = (kind != KIND_NONE) && (id == cfg_id_model) && (!is_err || r.inner_kind != INNER_NONE);
    r.accepted = ok;
    if (ok) begin
      r.seq_value = cap_rd16(seq_off);
      // SYN+ACK and RST+ACK carry the sequence plus one in the acknowledge
      if (kind == KIND_RST_ACK || kind == KIND_SYN_ACK) r.seq_value = r.seq_value - 16'd1;
    end
    return r;
  endfunction

  function automatic void capture_byte(input logic [7:0] b, input logic last);
    if (int'(cap_count) < CAPTURE_BYTES) cap_mem[cap_count] = b;
    if (cap_count < COUNT_MAX) cap_count = cap_count + 6'd1;
    if (last) begin
      exp_q.push_back(classify_capture(int'(cap_count)));
      cap_count = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_cnt, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (exp_q.size() == 0) begin
        report_mismatch("unexpected result, reply_kind", 16'(out_reply_kind), 16'h0);
      end else begin
        exp_head = exp_q.pop_front();
        if (out_reply_kind !== exp_head.reply_kind)
          report_mismatch("reply_kind", 16'(out_reply_kind), 16'(exp_head.reply_kind));
        if (out_unreach_code !== exp_head.unreach_code)
          report_mismatch("unreach_code", 16'(out_unreach_code), 16'(exp_head.unreach_code));
        if (out_inner_kind !== exp_head.inner_kind)
          report_mismatch("inner_kind", 16'(out_inner_kind), 16'(exp_head.inner_kind));
        if (out_seq_value !== exp_head.seq_value)
          report_mismatch("seq_value", out_seq_value, exp_head.seq_value);
        if (out_accepted !== exp_head.accepted)
          report_mismatch("accepted", 16'(out_accepted), 16'(exp_head.accepted));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_len != 0) begin
      hold_cnt = hold_len;
      hold_len = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_pkt_byte = b;
    in_last_byte = last;
    do @(posedge clk); while (!in_ready);
    capture_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_packet(input pkt_q_t p);
    foreach (p[i]) send_byte(p[i], i == p.size() - 1);
  endtask

  // Drop valid, then wait for every outstanding result plus the pipeline depth
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_probe_id(input logic [15:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_probe_id = v;
    do @(posedge clk); while (!cfg_ready);
    cfg_id_model = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic pkt_q_t build_packet(input int len, input logic [7:0] proto,
                                          input logic [7:0] sel, input logic [7:0] inner_proto,
                                          input logic [7:0] inner_type, input id_mode_t idm);
    logic [7:0]  raw [80];
    logic [15:0] id;
    pkt_q_t      p;
    foreach (raw[i]) raw[i] = 8'($urandom);
    raw[OFF_PROTO] = proto;
    raw[OFF_INNER_PROTO] = inner_proto;
    raw[OFF_INNER_TYPE] = inner_type;
    if (idm != ID_RANDOM) begin
      id = (idm == ID_MATCH) ? cfg_id_model : ~cfg_id_model;
      // place the identifier at every offset a reply kind may use
      {raw[0], raw[1]} = id;
      {raw[OFF_ID_REPLY], raw[OFF_ID_REPLY + 1]} = id;
      {raw[OFF_ID_TCP_ACK], raw[OFF_ID_TCP_ACK + 1]} = id;
      {raw[OFF_ID_INNER], raw[OFF_ID_INNER + 1]} = id;
    end
    // TCP flags share a byte with the quoted identifier, so set them last
    if (proto == PROTO_TCP) raw[OFF_TCP_FLAGS] = sel;
    else raw[OFF_ICMP_TYPE] = sel;
    for (int i = 0; i < len; i++) p.push_back(raw[i]);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_identifier();
    // probe_id is 0 out of reset
    send_packet(build_packet(28, PROTO_ICMP, ICMP_ECHO_REQ, 8'h00, 8'h00, ID_MATCH));
  endtask

  task automatic test_tcp_flags();
    logic [7:0] flags [7];
    pkt_q_t     p;
    flags = '{F_FIN, F_RST | F_ACK, F_SYN | F_ACK, F_ACK, 8'h00,
              F_URG | F_SYN, F_FIN | F_RST | F_SYN | F_ACK};
    foreach (flags[i])
      send_packet(build_packet(40, PROTO_TCP, flags[i], 8'h00, 8'h00, ID_MATCH));
    // acknowledge low half of zero wraps on the decrement
    p = build_packet(40, PROTO_TCP, F_SYN | F_ACK, 8'h00, 8'h00, ID_MATCH);
    p[OFF_ACK_LOW] = 8'h00;
    p[OFF_ACK_LOW + 1] = 8'h00;
    send_packet(p);
  endtask

  task automatic test_icmp_kinds();
    send_packet(build_packet(28, PROTO_ICMP, ICMP_ECHO_REPLY, 8'h00, 8'h00, ID_MATCH));
    send_packet(build_packet(56, PROTO_ICMP, ICMP_UNREACH, PROTO_TCP, 8'h00, ID_MATCH));
    send_packet(build_packet(56, PROTO_ICMP, ICMP_TIME_EXC, PROTO_UDP, 8'h00, ID_MATCH));
    send_packet(build_packet(56, PROTO_ICMP, ICMP_UNREACH, PROTO_ICMP, ICMP_ECHO_REQ,
                             ID_MATCH));
    // quoted ICMP that is not an echo leaves the inner probe unknown
    send_packet(build_packet(56, PROTO_ICMP, ICMP_TIME_EXC, PROTO_ICMP, ICMP_ECHO_REPLY,
                             ID_MATCH));
    send_packet(build_packet(56, PROTO_ICMP, ICMP_UNREACH, PROTO_OTHER, 8'h00, ID_MATCH));
    send_packet(build_packet(28, PROTO_ICMP, ICMP_OTHER_TYPE, 8'h00, 8'h00, ID_MATCH));
  endtask

  task automatic test_udp_and_unknown();
    send_packet(build_packet(28, PROTO_UDP, 8'($urandom), 8'h00, 8'h00, ID_MATCH));
    send_packet(build_packet(20, PROTO_OTHER, 8'($urandom), 8'h00, 8'h00, ID_MATCH));
  endtask

  task automatic test_short_packets();
    send_packet(build_packet(1, PROTO_TCP, F_ACK, 8'h00, 8'h00, ID_MATCH));
    send_packet(build_packet(19, PROTO_TCP, F_ACK, 8'h00, 8'h00, ID_MATCH));
    send_packet(build_packet(39, PROTO_TCP, F_ACK, 8'h00, 8'h00, ID_MATCH));
    send_packet(build_packet(27, PROTO_ICMP, ICMP_ECHO_REQ, 8'h00, 8'h00, ID_MATCH));
    send_packet(build_packet(55, PROTO_ICMP, ICMP_UNREACH, PROTO_TCP, 8'h00, ID_MATCH));
    send_packet(build_packet(27, PROTO_UDP, 8'h00, 8'h00, 8'h00, ID_MATCH));
  endtask

  task automatic test_id_mismatch();
    send_packet(build_packet(40, PROTO_TCP, F_ACK, 8'h00, 8'h00, ID_WRONG));
    // code and inner kind are still reported
    send_packet(build_packet(56, PROTO_ICMP, ICMP_UNREACH, PROTO_UDP, 8'h00, ID_WRONG));
  endtask

  task automatic test_long_packets();
    // byte count saturates and bytes past the capture window are dropped
    send_packet(build_packet(70, PROTO_TCP, F_RST | F_ACK, 8'h00, 8'h00, ID_MATCH));
  endtask

  task automatic test_backpressure();
    int unsigned snd_keep;
    int unsigned rcv_keep;
    snd_keep = snd_idle;
    rcv_keep = rcv_idle;
    wait_drained();
    snd_idle = 0;
    rcv_idle = 0;
    hold_len = 200;
    // short packets keep coming while the receiver holds off
    repeat (12)
      send_packet(build_packet($urandom_range(1, 3), 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom), ID_RANDOM));
    wait_drained();
    snd_idle = snd_keep;
    rcv_idle = rcv_keep;
  endtask

  task automatic test_random_traffic(input int unsigned snd, input int unsigned rcv,
                                     input logic [15:0] id);
    int         start;
    int         pkts;
    int         len;
    int         m;
    logic [7:0] proto;
    logic [7:0] sel;
    logic [7:0] iproto;
    logic [7:0] itype;
    id_mode_t   idm;
    write_probe_id(id);
    snd_idle = snd;
    rcv_idle = rcv;
    start = bytes_sent;
    pkts = 0;
    while ((bytes_sent - start) < 40 || pkts < 2) begin
      m = $urandom_range(0, 99);
      idm = ($urandom_range(0, 9) < 8) ? ID_MATCH : (($urandom_range(0, 1) != 0) ? ID_WRONG
                                                                                 : ID_RANDOM);
      sel = 8'($urandom);
      iproto = 8'($urandom);
      itype = 8'($urandom);
      if (m < 30) begin
        proto = PROTO_TCP;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 70) : $urandom_range(40, 46);
        case ($urandom_range(0, 9))
          0: sel = F_FIN;
          1: sel = F_RST;
          2: sel = F_RST | F_ACK;
          3: sel = F_SYN;
          4: sel = F_SYN | F_ACK;
          5: sel = F_ACK;
          6: sel = F_PSH | F_ACK;
          7: sel = F_URG | F_ACK;
          default: ;
        endcase
      end else if (m < 45) begin
        proto = PROTO_ICMP;
        len = $urandom_range(28, 36);
        sel = ($urandom_range(0, 1) != 0) ? ICMP_ECHO_REQ : ICMP_ECHO_REPLY;
      end else if (m < 65) begin
        proto = PROTO_ICMP;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(56, 70) : $urandom_range(56, 60);
        sel = ($urandom_range(0, 1) != 0) ? ICMP_UNREACH : ICMP_TIME_EXC;
        case ($urandom_range(0, 3))
          0: iproto = PROTO_TCP;
          1: iproto = PROTO_UDP;
          2: iproto = PROTO_ICMP;
          default: ;
        endcase
        if ($urandom_range(0, 1) != 0) itype = ICMP_ECHO_REQ;
      end else if (m < 75) begin
        proto = PROTO_UDP;
        len = $urandom_range(28, 36);
      end else if (m < 88) begin
        // well-formed header, cut short
        case ($urandom_range(0, 2))
          0: proto = PROTO_TCP;
          1: proto = PROTO_ICMP;
          default: proto = PROTO_UDP;
        endcase
        if (proto == PROTO_ICMP) begin
          case ($urandom_range(0, 3))
            0: sel = ICMP_ECHO_REQ;
            1: sel = ICMP_ECHO_REPLY;
            2: sel = ICMP_UNREACH;
            default: sel = ICMP_TIME_EXC;
          endcase
        end else if (proto == PROTO_TCP) begin
          sel = F_ACK;
        end
        iproto = PROTO_TCP;
        len = $urandom_range(1, 55);
      end else begin
        proto = 8'($urandom);
        len = $urandom_range(1, 63);
      end
      send_packet(build_packet(len, proto, sel, iproto, itype, idm));
      pkts++;
    end
  endtask

  initial begin
    foreach (cap_mem[i]) cap_mem[i] = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_identifier();
    write_probe_id(16'hFFFF);
    test_tcp_flags();
    test_icmp_kinds();
    test_udp_and_unknown();
    test_short_packets();
    test_id_mismatch();
    test_long_packets();
    test_backpressure();
    test_random_traffic(86, 26, 16'h0000);
    test_random_traffic(0, 0, 16'($urandom));

    wait_drained();
    if (mismatch_count == 0 && exp_q.size() == 0) begin
      $display("PASS probe_reply_classifier_top");
    end else begin
      $display("FAIL probe_reply_classifier_top");
    end
    $finish;
  end

endmodule
